FILE: rtl/ifs_pkg.sv
// Shared types and codes for the icosphere face subdivider.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ifs_pkg;

   localparam int IDX_W   = 12;
   localparam int COORD_W = 16;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_FACE  = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   localparam logic [1:0] KIND_VERT = 2'd0;
   localparam logic [1:0] KIND_FACE = 2'd1;
   localparam logic [1:0] KIND_ACK  = 2'd2;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_VFULL = 2'd1;
   localparam logic [1:0] ERR_EFULL = 2'd2;
   localparam logic [1:0] ERR_INDEX = 2'd3;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [IDX_W-1:0]          corner_a;
      logic [IDX_W-1:0]          corner_b;
      logic [IDX_W-1:0]          corner_c;
   } ifs_req_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic [IDX_W-1:0]          vertex_index;
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic [IDX_W-1:0]          tri_a;
      logic [IDX_W-1:0]          tri_b;
      logic [IDX_W-1:0]          tri_c;
      logic [1:0]                error;
      logic                      last;
   } ifs_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_LOAD, ST_CLR, ST_BAD, ST_SCAN, ST_SCAN_WAIT,
      ST_PLAN, ST_ERR_ACK, ST_EDGE, ST_RD_B, ST_SUM, ST_SQ, ST_ROOT0,
      ST_SQRT, ST_DIVI, ST_DIV, ST_DIVF, ST_COMMIT, ST_FACE
   } ifs_state_type;

   typedef enum logic [1:0] {
      EMIT_NONE, EMIT_ACK, EMIT_VERT, EMIT_FACE
   } ifs_emit_type;

   typedef struct packed {
      logic         take_req;
      logic         do_load;
      logic         clr_edges;
      logic         clr_verts;
      logic         scan_start;
      logic         scan_step;
      logic         edge_skip;
      logic         rd_a;
      logic         rd_b;
      logic         sum;
      logic         sq_step;
      logic         sqrt_init;
      logic         sqrt_step;
      logic         div_init;
      logic         div_step;
      logic         div_fin;
      logic         commit;
      logic         face_step;
      ifs_emit_type emit;
      logic [1:0]   ack_err;
      logic         ack_index;
   } ifs_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       full;
      logic       bad_corner;
      logic       scan_end;
      logic [1:0] need_err;
      logic       e_done;
      logic       reuse;
      logic       len_zero;
      logic       sq_last;
      logic       sqrt_last;
      logic       div_last;
      logic       comp_last;
      logic       face_last;
      logic       out_free;
   } ifs_sts_type;

endpackage
`default_nettype wire

FILE: rtl/ifs_ctrl.sv
// Sequencer for the subdivider: one item at a time through load, scan,
// normalize and emit phases. Depends on ifs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ifs_ctrl
   import ifs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             idle,
   input  wire ifs_sts_type sts,
   output ifs_cmd_type      cmd
);

   ifs_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (sts.func)
               FUNC_LOAD: state_in = ST_LOAD;
               FUNC_FACE: state_in = sts.bad_corner ? ST_BAD : ST_SCAN;
               default:   state_in = ST_CLR;
            endcase
         end
         ST_LOAD, ST_CLR, ST_BAD, ST_ERR_ACK: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.scan_end) state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_PLAN;
         ST_PLAN: state_in = (sts.need_err != ERR_NONE) ? ST_ERR_ACK : ST_EDGE;
         ST_EDGE: begin
            if (sts.e_done) state_in = ST_FACE;
            else if (!sts.reuse) state_in = ST_RD_B;
         end
         ST_RD_B: state_in = ST_SUM;
         ST_SUM:  state_in = ST_SQ;
         ST_SQ: begin
            if (sts.sq_last) state_in = ST_ROOT0;
         end
         ST_ROOT0: state_in = sts.len_zero ? ST_COMMIT : ST_SQRT;
         ST_SQRT: begin
            if (sts.sqrt_last) state_in = ST_DIVI;
         end
         ST_DIVI: state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_last) state_in = ST_DIVF;
         end
         ST_DIVF: state_in = sts.comp_last ? ST_COMMIT : ST_DIVI;
         ST_COMMIT: begin
            if (sts.out_free) state_in = ST_EDGE;
         end
         ST_FACE: begin
            if (sts.out_free && sts.face_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      idle = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: cmd.take_req = req_valid;
         ST_DISPATCH: cmd.scan_start = 1'b1;
         ST_LOAD: begin
            if (sts.out_free) begin
               cmd.emit      = EMIT_ACK;
               cmd.ack_err   = sts.full ? ERR_VFULL : ERR_NONE;
               cmd.ack_index = !sts.full;
               cmd.do_load   = !sts.full;
            end
         end
         ST_CLR: begin
            if (sts.out_free) begin
               cmd.emit      = EMIT_ACK;
               cmd.clr_edges = 1'b1;
               cmd.clr_verts = (sts.func == FUNC_CLEAR);
            end
         end
         ST_BAD: begin
            if (sts.out_free) begin
               cmd.emit    = EMIT_ACK;
               cmd.ack_err = ERR_INDEX;
            end
         end
         ST_ERR_ACK: begin
            if (sts.out_free) begin
               cmd.emit    = EMIT_ACK;
               cmd.ack_err = sts.need_err;
            end
         end
         ST_SCAN: cmd.scan_step = !sts.scan_end;
         ST_EDGE: begin
            if (!sts.e_done) begin
               cmd.edge_skip = sts.reuse;
               cmd.rd_a      = !sts.reuse;
            end
         end
         ST_RD_B:  cmd.rd_b = 1'b1;
         ST_SUM:   cmd.sum = 1'b1;
         ST_SQ:    cmd.sq_step = 1'b1;
         ST_ROOT0: cmd.sqrt_init = !sts.len_zero;
         ST_SQRT:  cmd.sqrt_step = 1'b1;
         ST_DIVI:  cmd.div_init = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_DIVF:  cmd.div_fin = 1'b1;
         ST_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               cmd.emit   = EMIT_VERT;
            end
         end
         ST_FACE: begin
            if (sts.out_free) begin
               cmd.emit      = EMIT_FACE;
               cmd.face_step = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/ifs_datapath.sv
// Datapath: vertex store, edge table, shared square-root and divide
// iterations, and the result register. Depends on ifs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ifs_datapath
   import ifs_pkg::*;
#(
   parameter int MAX_VERTICES = 4096,
   parameter int MAX_EDGES    = 4096,
   parameter int COORD_BITS   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ifs_req_type req_data,
   input  wire ifs_cmd_type cmd,
   output ifs_sts_type      sts,
   output ifs_rsp_type      rsp_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall
);

   localparam int CW    = (COORD_BITS < 16) ? COORD_BITS : 16;
   localparam int FRACB = CW - 2;
   localparam int VCAP  = (MAX_VERTICES < 4096) ? MAX_VERTICES : 4096;
   localparam int VA_W  = $clog2(VCAP);
   localparam int VC_W  = $clog2(VCAP + 1);
   localparam int EA_W  = $clog2(MAX_EDGES);
   localparam int EC_W  = $clog2(MAX_EDGES + 1);
   localparam int SW    = CW + 1;
   localparam int LW    = 2 * SW + 2;
   localparam int VE_W  = 3 * CW;
   localparam int EE_W  = 3 * IDX_W;

   function automatic logic [1:0] next3(input logic [1:0] i);
      next3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
   endfunction

   // control state
   logic [VC_W-1:0] vcount_ff, vcount_in;
   logic [EC_W-1:0] ecount_ff, ecount_in;
   logic [EC_W-1:0] sidx_ff;
   logic            spend_ff;
   logic            rsp_valid_ff;

   // payload
   ifs_req_type       req_ff;
   ifs_rsp_type       rsp_ff, rsp_in;
   logic [VE_W-1:0]   vmem [VCAP];
   logic [EE_W-1:0]   emem [MAX_EDGES];
   logic [VE_W-1:0]   vrd_ff, a_ff;
   logic [EE_W-1:0]   erd_ff;
   logic [2:0]        found_ff;
   logic [IDX_W-1:0]  fmid_ff [3];
   logic [IDX_W-1:0]  mid_ff [3];
   logic [1:0]        e_ff, face_ff, comp_ff;
   logic [5:0]        cnt_ff;
   logic signed [SW-1:0] s_ff [3];
   logic [LW-1:0]     len_ff;
   logic [63:0]       sqx_ff, sqres_ff, sqbit_ff;
   logic [32:0]       rem_ff;
   logic [CW-1:0]     quo_ff;
   logic [CW-1:0]     q_ff [3];

   logic [IDX_W-1:0] cn [3];
   logic [IDX_W-1:0] lo [3];
   logic [IDX_W-1:0] hi [3];
   logic             al1, al2a, al2b;
   logic [2:0]       alias_v, newe;
   logic [1:0]       alias_src [3];
   logic [1:0]       need;
   logic             out_free;
   logic [VA_W-1:0]  vrd_addr;
   logic [VE_W-1:0]  qcat;
   logic [SW-1:0]    mag_sq, mag_dv;
   logic [63:0]      num, sq_t;
   logic [32:0]      dv_t;
   logic [31:0]      root;
   logic [CW-1:0]    capped;

   assign cn[0] = req_ff.corner_a;
   assign cn[1] = req_ff.corner_b;
   assign cn[2] = req_ff.corner_c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo[i] = (cn[i] < cn[next3(2'(i))]) ? cn[i] : cn[next3(2'(i))];
         hi[i] = (cn[i] < cn[next3(2'(i))]) ? cn[next3(2'(i))] : cn[i];
      end
   end

   // edges repeated inside one face reuse the first new vertex
   always_comb begin
      al1  = !found_ff[0] && !found_ff[1] && lo[0] == lo[1] && hi[0] == hi[1];
      al2a = !found_ff[2] && !found_ff[0] && lo[0] == lo[2] && hi[0] == hi[2];
      al2b = !found_ff[2] && !found_ff[1] && !al1 && lo[1] == lo[2] && hi[1] == hi[2];
      alias_v      = {al2a || al2b, al1, 1'b0};
      alias_src[0] = 2'd0;
      alias_src[1] = 2'd0;
      alias_src[2] = al2b ? 2'd1 : 2'd0;
      newe = ~found_ff & ~alias_v;
      need = 2'(newe[0]) + 2'(newe[1]) + 2'(newe[2]);
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sts          = '0;
      sts.func     = req_ff.func;
      sts.full     = (vcount_ff == VC_W'(VCAP));
      sts.bad_corner = ({1'b0, cn[0]} >= 13'(vcount_ff)) ||
                       ({1'b0, cn[1]} >= 13'(vcount_ff)) ||
                       ({1'b0, cn[2]} >= 13'(vcount_ff));
      sts.scan_end = (sidx_ff == ecount_ff);
      if (18'(vcount_ff) + 18'(need) > 18'(VCAP)) begin
         sts.need_err = ERR_VFULL;
      end else if (18'(ecount_ff) + 18'(need) > 18'(MAX_EDGES)) begin
         sts.need_err = ERR_EFULL;
      end else begin
         sts.need_err = ERR_NONE;
      end
      sts.e_done    = (e_ff == 2'd3);
      sts.reuse     = (e_ff != 2'd3) && !newe[e_ff];
      sts.len_zero  = (len_ff == '0);
      sts.sq_last   = (cnt_ff == 6'd2);
      sts.sqrt_last = (cnt_ff == 6'd31);
      sts.div_last  = (cnt_ff == 6'(CW - 1));
      sts.comp_last = (comp_ff == 2'd2);
      sts.face_last = (face_ff == 2'd3);
      sts.out_free  = out_free;
   end

   // counters
   always_comb begin
      vcount_in = vcount_ff;
      ecount_in = ecount_ff;
      if (cmd.do_load || cmd.commit) vcount_in = vcount_ff + 1'b1;
      if (cmd.commit) ecount_in = ecount_ff + 1'b1;
      if (cmd.clr_verts) vcount_in = '0;
      if (cmd.clr_edges) ecount_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         ecount_ff    <= '0;
         spend_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sidx_ff      <= '0;
      end else begin
         vcount_ff <= vcount_in;
         ecount_ff <= ecount_in;
         spend_ff  <= cmd.scan_step;
         if (cmd.scan_start) sidx_ff <= '0;
         else if (cmd.scan_step) sidx_ff <= sidx_ff + 1'b1;
         if (cmd.emit != EMIT_NONE) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // vertex store
   assign qcat = sts.len_zero ? '0 : {q_ff[0], q_ff[1], q_ff[2]};
   assign vrd_addr = cmd.rd_b ? cn[next3(e_ff)][VA_W-1:0] : cn[e_ff][VA_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.do_load) begin
         vmem[vcount_ff[VA_W-1:0]] <= {req_ff.coord_x[CW-1:0], req_ff.coord_y[CW-1:0],
                                       req_ff.coord_z[CW-1:0]};
      end else if (cmd.commit) begin
         vmem[vcount_ff[VA_W-1:0]] <= qcat;
      end
      if (cmd.rd_a || cmd.rd_b) vrd_ff <= vmem[vrd_addr];
   end

   // edge table
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         emem[ecount_ff[EA_W-1:0]] <= {lo[e_ff], hi[e_ff], IDX_W'(vcount_ff)};
      end
      erd_ff <= emem[sidx_ff[EA_W-1:0]];
   end

   // arithmetic helpers
   always_comb begin
      mag_sq = s_ff[cnt_ff[1:0]][SW-1] ? SW'(-s_ff[cnt_ff[1:0]]) : SW'(s_ff[cnt_ff[1:0]]);
      mag_dv = s_ff[comp_ff][SW-1] ? SW'(-s_ff[comp_ff]) : SW'(s_ff[comp_ff]);
      root   = sqres_ff[31:0];
      num    = (64'(mag_dv) << (FRACB + 14)) + 64'(root >> 1);
      sq_t   = sqres_ff + sqbit_ff;
      dv_t   = {rem_ff[31:0], quo_ff[CW-1]};
      capped = (quo_ff > {1'b0, {(CW - 1){1'b1}}}) ? {1'b0, {(CW - 1){1'b1}}} : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         req_ff  <= req_data;
         e_ff    <= 2'd0;
         face_ff <= 2'd0;
      end
      if (cmd.scan_start) found_ff <= 3'b000;
      if (spend_ff) begin
         for (int k = 0; k < 3; k++) begin
            if (!found_ff[k] && erd_ff[EE_W-1 -: IDX_W] == lo[k] &&
                erd_ff[2*IDX_W-1 -: IDX_W] == hi[k]) begin
               found_ff[k] <= 1'b1;
               fmid_ff[k]  <= erd_ff[IDX_W-1:0];
            end
         end
      end
      if (cmd.edge_skip) begin
         mid_ff[e_ff] <= found_ff[e_ff] ? fmid_ff[e_ff] : mid_ff[alias_src[e_ff]];
         e_ff <= e_ff + 2'd1;
      end
      if (cmd.commit) begin
         mid_ff[e_ff] <= IDX_W'(vcount_ff);
         e_ff <= e_ff + 2'd1;
      end
      if (cmd.rd_b) a_ff <= vrd_ff;
      if (cmd.sum) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[k] <= SW'($signed(a_ff[VE_W-1-k*CW -: CW])) +
                       SW'($signed(vrd_ff[VE_W-1-k*CW -: CW]));
         end
         len_ff  <= '0;
         cnt_ff  <= '0;
         comp_ff <= 2'd0;
      end
      if (cmd.sq_step) begin
         len_ff <= len_ff + LW'(mag_sq) * LW'(mag_sq);
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.sqrt_init) begin
         sqx_ff   <= 64'(len_ff) << 28;
         sqres_ff <= '0;
         sqbit_ff <= 64'd1 << 62;
         cnt_ff   <= '0;
      end
      if (cmd.sqrt_step) begin
         if (sqx_ff >= sq_t) begin
            sqx_ff   <= sqx_ff - sq_t;
            sqres_ff <= (sqres_ff >> 1) + sqbit_ff;
         end else begin
            sqres_ff <= sqres_ff >> 1;
         end
         sqbit_ff <= sqbit_ff >> 2;
         cnt_ff   <= cnt_ff + 6'd1;
      end
      if (cmd.div_init) begin
         rem_ff <= {1'b0, num[CW+31:CW]};
         quo_ff <= num[CW-1:0];
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (dv_t >= {1'b0, root}) begin
            rem_ff <= dv_t - {1'b0, root};
            quo_ff <= {quo_ff[CW-2:0], 1'b1};
         end else begin
            rem_ff <= dv_t;
            quo_ff <= {quo_ff[CW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.div_fin) begin
         q_ff[comp_ff] <= s_ff[comp_ff][SW-1] ? -capped : capped;
         comp_ff <= comp_ff + 2'd1;
      end
      if (cmd.face_step) face_ff <= face_ff + 2'd1;
      if (cmd.emit != EMIT_NONE) rsp_ff <= rsp_in;
   end

   // result formatting
   always_comb begin
      rsp_in = '0;
      case (cmd.emit)
         EMIT_ACK: begin
            rsp_in.kind         = KIND_ACK;
            rsp_in.vertex_index = cmd.ack_index ? IDX_W'(vcount_ff) : '0;
            rsp_in.error        = cmd.ack_err;
            rsp_in.last         = 1'b1;
         end
         EMIT_VERT: begin
            rsp_in.kind         = KIND_VERT;
            rsp_in.vertex_index = IDX_W'(vcount_ff);
            rsp_in.out_x        = COORD_W'($signed(qcat[VE_W-1 -: CW]));
            rsp_in.out_y        = COORD_W'($signed(qcat[2*CW-1 -: CW]));
            rsp_in.out_z        = COORD_W'($signed(qcat[CW-1:0]));
         end
         EMIT_FACE: begin
            rsp_in.kind = KIND_FACE;
            rsp_in.last = (face_ff == 2'd3);
            case (face_ff)
               2'd0: begin
                  rsp_in.tri_a = cn[0]; rsp_in.tri_b = mid_ff[0]; rsp_in.tri_c = mid_ff[2];
               end
               2'd1: begin
                  rsp_in.tri_a = cn[1]; rsp_in.tri_b = mid_ff[1]; rsp_in.tri_c = mid_ff[0];
               end
               2'd2: begin
                  rsp_in.tri_a = cn[2]; rsp_in.tri_b = mid_ff[2]; rsp_in.tri_c = mid_ff[1];
               end
               default: begin
                  rsp_in.tri_a = mid_ff[0]; rsp_in.tri_b = mid_ff[1]; rsp_in.tri_c = mid_ff[2];
               end
            endcase
         end
         default: rsp_in = '0;
      endcase
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/icosphere_face_subdivider_top.sv
// Top level of the icosphere face subdivider: sequencer plus datapath.
// Depends on ifs_pkg, ifs_ctrl and ifs_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Channel  | direction | handshake          | payload
// req_     | in        | req_valid/req_stall | ifs_req_type (func, coords, corners)
// rsp_     | out       | rsp_valid/rsp_stall | ifs_rsp_type (kind, vertex, face, error)
//
// Steps: load, end pass and clear mesh answer with one acknowledge. A face
// runs an edge-table scan (one table read a cycle), then for each new vertex
// 3 squares, 32 root steps and a 1-bit-per-cycle divide per axis; a reused
// edge is skipped, and the edge loop closes before the 4 face results.
// Reset clears counts and control at once; the edge table is empty by count.
// A stalled result register blocks only the next emit; one item is in work.
module icosphere_face_subdivider_top
   import ifs_pkg::*;
#(
   parameter int MAX_VERTICES = 4096,
   parameter int MAX_EDGES    = 4096,
   parameter int COORD_BITS   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire ifs_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ifs_rsp_type      rsp_data
);

   ifs_cmd_type cmd;
   ifs_sts_type sts;
   logic        idle;

   // hold off new items until the sequencer is back in idle
   assign req_stall = !idle;

   ifs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .idle      (idle),
      .sts       (sts),
      .cmd       (cmd)
   );

   ifs_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule
`default_nettype wire

FILE: test/tb_icosphere_face_subdivider_top.sv
// Self-checking testbench for icosphere_face_subdivider_top: loads, face
// subdivision, end pass and clear mesh, checked against a local predictor.
// Depends on ifs_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_icosphere_face_subdivider_top;
   import ifs_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int STUCK_LIMIT = 50000;
   localparam int TAIL_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ifs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ifs_rsp_type rsp_data;

   // Percent of cycles on which the sender holds back and the receiver stalls.
   int send_idle = 19;
   int recv_idle = 55;

   ifs_req_type items_to_send[$];
   ifs_rsp_type awaited_results[$];
   logic        req_taken = 1'b0;
   int          mismatch_count = 0;
   int          stuck_cycles = 0;

   // Predictor state: vertex store, vertex count, edge table.
   int           mesh_x [STORE_DEPTH];
   int           mesh_y [STORE_DEPTH];
   int           mesh_z [STORE_DEPTH];
   int unsigned  mesh_count = 0;
   logic [11:0]  edge_lo  [STORE_DEPTH];
   logic [11:0]  edge_hi  [STORE_DEPTH];
   logic [11:0]  edge_mid [STORE_DEPTH];
   int unsigned  edge_count = 0;

   icosphere_face_subdivider_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Append one result to the awaited list.
   function automatic void note_result(ifs_rsp_type r);
      awaited_results = {awaited_results, r};
   endfunction

   // Append one item to the send list.
   function automatic void add_item(ifs_req_type it);
      items_to_send = {items_to_send, it};
   endfunction

   function automatic ifs_rsp_type make_result(logic [1:0] kind, logic [11:0] vi,
                                               int x, int y, int z,
                                               logic [11:0] ta, logic [11:0] tb,
                                               logic [11:0] tc, logic [1:0] err);
      ifs_rsp_type r;
      r.kind         = kind;
      r.vertex_index = vi;
      r.out_x        = x[15:0];
      r.out_y        = y[15:0];
      r.out_z        = z[15:0];
      r.tri_a        = ta;
      r.tri_b        = tb;
      r.tri_c        = tc;
      r.error        = err;
      r.last         = 1'b0;
      return r;
   endfunction

   // Integer square root, bit-pair method.
   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scale the midpoint sum back onto the unit sphere in Q1.14.
   task automatic project_to_sphere(input int sx, input int sy, input int sz,
                                    output int qx, output int qy, output int qz);
      longint unsigned mag [3];
      longint unsigned len2;
      longint unsigned r;
      longint unsigned v;
      int s [3];
      int q [3];
      s[0] = sx; s[1] = sy; s[2] = sz;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (s[i] < 0) ? longint'(-s[i]) : longint'(s[i]);
         len2   = len2 + mag[i] * mag[i];
      end
      if (len2 == 0) begin
         q[0] = 0; q[1] = 0; q[2] = 0;
      end else begin
         r = root64(len2 << 28);
         for (int i = 0; i < 3; i++) begin
            v = ((mag[i] << 28) + (r >> 1)) / r;
            if (v > 32767) v = 32767;
            q[i] = (s[i] < 0) ? -int'(v) : int'(v);
         end
      end
      qx = q[0]; qy = q[1]; qz = q[2];
   endtask

   task automatic subdivide_face(input ifs_req_type it);
      int unsigned cn [3];
      int unsigned lo [3];
      int unsigned hi [3];
      int unsigned mid [3];
      int          found [3];
      int          twin [3];
      int unsigned need;
      int unsigned a, b, nv;
      int          qx, qy, qz;
      ifs_rsp_type r;
      cn[0] = it.corner_a; cn[1] = it.corner_b; cn[2] = it.corner_c;
      need  = 0;
      for (int i = 0; i < 3; i++) begin
         if (cn[i] >= mesh_count) begin
            r      = make_result(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, ERR_INDEX);
            r.last = 1'b1;
            note_result(r);
            return;
         end
      end
      for (int i = 0; i < 3; i++) begin
         a        = cn[i];
         b        = cn[(i + 1) % 3];
         lo[i]    = (a < b) ? a : b;
         hi[i]    = (a < b) ? b : a;
         found[i] = -1;
         twin[i]  = -1;
         for (int e = 0; e < edge_count; e++)
            if (found[i] < 0 && edge_lo[e] == lo[i] && edge_hi[e] == hi[i]) found[i] = e;
         if (found[i] < 0) begin
            // A key made earlier in this face is reused, not made again.
            for (int j = 0; j < i; j++)
               if (found[j] < 0 && twin[j] < 0 && lo[j] == lo[i] && hi[j] == hi[i])
                  twin[i] = j;
            if (twin[i] < 0) need++;
         end
      end
      if (mesh_count + need > STORE_DEPTH || edge_count + need > STORE_DEPTH) begin
         r = make_result(KIND_ACK, 0, 0, 0, 0, 0, 0, 0,
                         (mesh_count + need > STORE_DEPTH) ? ERR_VFULL : ERR_EFULL);
         r.last = 1'b1;
         note_result(r);
         return;
      end
      for (int i = 0; i < 3; i++) begin
         if (found[i] >= 0) begin
            mid[i] = edge_mid[found[i]];
         end else if (twin[i] >= 0) begin
            mid[i] = mid[twin[i]];
         end else begin
            a  = cn[i];
            b  = cn[(i + 1) % 3];
            nv = mesh_count;
            project_to_sphere(mesh_x[a] + mesh_x[b], mesh_y[a] + mesh_y[b],
                              mesh_z[a] + mesh_z[b], qx, qy, qz);
            mesh_x[nv] = qx; mesh_y[nv] = qy; mesh_z[nv] = qz;
            mesh_count++;
            edge_lo[edge_count]  = lo[i];
            edge_hi[edge_count]  = hi[i];
            edge_mid[edge_count] = nv;
            edge_count++;
            mid[i] = nv;
            note_result(make_result(KIND_VERT, nv, qx, qy, qz, 0, 0, 0, ERR_NONE));
         end
      end
      note_result(make_result(KIND_FACE, 0, 0, 0, 0, cn[0], mid[0], mid[2], ERR_NONE));
      note_result(make_result(KIND_FACE, 0, 0, 0, 0, cn[1], mid[1], mid[0], ERR_NONE));
      note_result(make_result(KIND_FACE, 0, 0, 0, 0, cn[2], mid[2], mid[1], ERR_NONE));
      r      = make_result(KIND_FACE, 0, 0, 0, 0, mid[0], mid[1], mid[2], ERR_NONE);
      r.last = 1'b1;
      note_result(r);
   endtask

   // Work out the results of one accepted item and queue them.
   task automatic predict_results(input ifs_req_type it);
      ifs_rsp_type r;
      case (it.func)
         FUNC_LOAD: begin
            if (mesh_count >= STORE_DEPTH) begin
               r = make_result(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, ERR_VFULL);
            end else begin
               mesh_x[mesh_count] = it.coord_x;
               mesh_y[mesh_count] = it.coord_y;
               mesh_z[mesh_count] = it.coord_z;
               r = make_result(KIND_ACK, mesh_count, 0, 0, 0, 0, 0, 0, ERR_NONE);
               mesh_count++;
            end
            r.last = 1'b1;
            note_result(r);
         end
         FUNC_FACE: begin
            subdivide_face(it);
         end
         default: begin
            if (it.func == FUNC_CLEAR) mesh_count = 0;
            edge_count = 0;
            r      = make_result(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, ERR_NONE);
            r.last = 1'b1;
            note_result(r);
         end
      endcase
   endtask

   // Sample both channels at the rising edge: predict on accept, check on accept.
   always @(posedge clock) begin
      ifs_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) predict_results(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: %p", rsp_data);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result differs: expected %p, got %p", want, rsp_data);
               end
            end
         end
         // Watchdog: count cycles with work outstanding and no item moving.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles <= 0;
         end else if (req_valid || items_to_send.size() != 0 ||
                      awaited_results.size() != 0) begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
               $display("icosphere_face_subdivider_top: mismatch");
               $finish;
            end
         end
      end
   end

   // Drive at the falling edge: hold a stalled item, otherwise advance or idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_data  <= items_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // Item with random filler in the fields its function ignores.
   function automatic ifs_req_type random_item(logic [1:0] func);
      ifs_req_type it;
      it.coord_x  = $urandom;
      it.coord_y  = $urandom;
      it.coord_z  = $urandom;
      it.corner_a = $urandom;
      it.corner_b = $urandom;
      it.corner_c = $urandom;
      it.func     = func;
      return it;
   endfunction

   task automatic queue_load(input int x, input int y, input int z);
      ifs_req_type it;
      it         = random_item(FUNC_LOAD);
      it.coord_x = x[15:0];
      it.coord_y = y[15:0];
      it.coord_z = z[15:0];
      add_item(it);
   endtask

   task automatic queue_face(input int a, input int b, input int c);
      ifs_req_type it;
      it          = random_item(FUNC_FACE);
      it.corner_a = a[11:0];
      it.corner_b = b[11:0];
      it.corner_c = c[11:0];
      add_item(it);
   endtask

   // Hold until everything sent has been answered, then let the block settle.
   task automatic drain_block();
      while (items_to_send.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      int sent;
      int verts;
      int ops;
      int r;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, shared and reversed edges, repeated corners,
      // zero midpoint, bad corners, end pass and clear mesh.
      add_item(random_item(FUNC_CLEAR));
      queue_load(16384, 0, 0);
      queue_load(0, 16384, 0);
      queue_load(0, 0, 16384);
      queue_load(-32768, -32768, -32768);
      queue_load(32767, 32767, 32767);
      queue_load(-16384, 0, 0);
      queue_face(0, 1, 2);
      queue_face(2, 1, 0);
      queue_face(0, 3, 0);
      queue_face(0, 5, 1);
      queue_face(3, 4, 4);
      queue_face(4095, 0, 1);
      queue_face(0, 4000, 1);
      add_item(random_item(FUNC_END));
      queue_face(0, 1, 2);
      queue_load(-1, -1, -1);
      add_item(random_item(FUNC_CLEAR));
      queue_face(0, 0, 0);
      add_item(random_item(FUNC_END));
      drain_block();

      // Random meshes: small vertex sets so that faces share edges.
      send_idle = 55;
      recv_idle = 19;
      sent = 0;
      while (sent < 400) begin
         if (sent >= 200 && send_idle != 0) begin
            drain_block();
            send_idle = 0;
            recv_idle = 0;
         end
         add_item(random_item(FUNC_CLEAR));
         verts = $urandom_range(10, 3);
         for (int i = 0; i < verts; i++) queue_load($urandom, $urandom, $urandom);
         ops = $urandom_range(12, 4);
         for (int i = 0; i < ops; i++) begin
            r = $urandom_range(99);
            if (r < 70)
               queue_face($urandom_range(verts - 1), $urandom_range(verts - 1),
                          $urandom_range(verts - 1));
            else if (r < 78)
               queue_face($urandom_range(4095, 2048), $urandom_range(verts - 1),
                          $urandom_range(verts - 1));
            else if (r < 88)
               add_item(random_item(FUNC_END));
            else
               queue_load($urandom, $urandom, $urandom);
         end
         sent = sent + 1 + verts + ops;
      end
      drain_block();

      if (mismatch_count == 0) begin
         $display("icosphere_face_subdivider_top: match");
      end else begin
         $display("icosphere_face_subdivider_top: mismatch");
      end
      $finish;
   end

endmodule

FILE: icosphere_face_subdivider_top.f
rtl/ifs_pkg.sv
rtl/ifs_ctrl.sv
rtl/ifs_datapath.sv
rtl/icosphere_face_subdivider_top.sv
test/tb_icosphere_face_subdivider_top.sv
